>>> hw/rtl/calendar_date_counter_assert.svh
// Assertion macros shared by the calendar date counter modules.
`ifndef CALENDAR_DATE_COUNTER_ASSERT_SVH
`define CALENDAR_DATE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cdc_pkg.sv
// Shared types, codes and calendar functions of the calendar date counter.
package cdc_pkg;

    localparam int DAY_COUNT_W     = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Command codes
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_MONTH = 3'd1;
    localparam logic [2:0] STAT_BAD_YEAR  = 3'd2;
    localparam logic [2:0] STAT_BAD_DAY   = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

    localparam logic [11:0] YEAR_LOW   = 12'd1900;
    localparam logic [11:0] YEAR_HIGH  = 12'd2100;
    localparam logic [11:0] YEAR_LAST  = 12'd4095;
    localparam logic [3:0]  MONTH_LAST = 4'd12;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic set_date;
        logic advance;
        logic count_dec;
        logic flag_ovf;
        logic out_write;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       at_end;
        logic       out_free;
    } ctrl_sts_t;

    // x divisible by 25, x < 1024; floor(x/25) = (x * 1311) >> 15 over this range
    function automatic logic mod25_zero(input logic [9:0] x);
        logic [20:0] prod;
        logic [5:0]  q;
        logic [9:0]  r;
        prod = {11'b0, x} * 21'd1311;
        q    = prod[20:15];
        r    = x - ({4'b0, q} * 10'd25);
        return (r == 10'd0);
    endfunction

    // Gregorian leap rule: 400 | y via 16 | y and 25 | y/16, 100 | y via 4 | y and 25 | y/4
    function automatic logic is_leap(input logic [11:0] y);
        logic div4;
        logic div100;
        logic div400;
        div4   = (y[1:0] == 2'b00);
        div100 = div4 && mod25_zero(y[11:2]);
        div400 = (y[3:0] == 4'b0000) && mod25_zero({2'b00, y[11:4]});
        return div400 || (div4 && !div100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        case (m)
            4'd0:                       len = 5'd0;
            4'd2:                       len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/cdc_datapath.sv
// Datapath: date registers, day counter, status and output register.
`include "calendar_date_counter_assert.svh"

module cdc_datapath #(
    parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cdc_pkg::ctrl_cmd_t                  cmd,
    output cdc_pkg::ctrl_sts_t                  sts,
    input  logic [1:0]                          in_cmd,
    input  logic [3:0]                          in_month,
    input  logic [4:0]                          in_day,
    input  logic [11:0]                         in_year,
    input  logic [cdc_pkg::DAY_COUNT_W-1:0]     in_count,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [3:0]                          out_month,
    output logic [4:0]                          out_day,
    output logic [11:0]                         out_year,
    output logic [2:0]                          out_status
);
    import cdc_pkg::*;

    logic [3:0]             month_reg, month_next;
    logic [4:0]             day_reg, day_next;
    logic [11:0]            year_reg, year_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_load;
    logic [1:0]             cmd_reg, cmd_next;
    logic [3:0]             nm_reg, nm_next;
    logic [4:0]             nd_reg, nd_next;
    logic [11:0]            ny_reg, ny_next;
    logic [2:0]             status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             out_month_reg, out_month_next;
    logic [4:0]             out_day_reg, out_day_next;
    logic [11:0]            out_year_reg, out_year_next;
    logic [2:0]             out_status_reg, out_status_next;

    logic [4:0] len_cur, len_new;
    logic       roll_day;
    logic       m_ok, y_ok, d_ok;

    generate
        if (COUNT_WIDTH <= DAY_COUNT_W) begin : g_cnt_trunc
            assign cnt_load = in_count[COUNT_WIDTH-1:0];
        end else begin : g_cnt_ext
            assign cnt_load = {{(COUNT_WIDTH-DAY_COUNT_W){1'b0}}, in_count};
        end
    endgenerate

    always_comb begin
        len_cur  = month_len(month_reg, year_reg);
        roll_day = (day_reg >= len_cur);
        m_ok     = (nm_reg >= 4'd1) && (nm_reg <= MONTH_LAST);
        y_ok     = (ny_reg >= YEAR_LOW) && (ny_reg <= YEAR_HIGH);
        len_new  = month_len(nm_reg, ny_reg);
        d_ok     = (nd_reg >= 5'd1) && (nd_reg <= len_new);

        month_next      = month_reg;
        day_next        = day_reg;
        year_next       = year_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        nm_next         = nm_reg;
        nd_next         = nd_reg;
        ny_next         = ny_reg;
        status_next     = status_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        out_year_next   = out_year_reg;
        out_status_next = out_status_reg;

        if (cmd.load) begin
            cmd_next    = in_cmd;
            nm_next     = in_month;
            nd_next     = in_day;
            ny_next     = in_year;
            cnt_next    = cnt_load;
            status_next = STAT_OK;
        end

        // Fields that pass their check stay written even if a later one fails
        if (cmd.set_date) begin
            if (!m_ok) begin
                status_next = STAT_BAD_MONTH;
            end else begin
                month_next = nm_reg;
                if (!y_ok) begin
                    status_next = STAT_BAD_YEAR;
                end else begin
                    year_next = ny_reg;
                    if (!d_ok) begin
                        status_next = STAT_BAD_DAY;
                    end else begin
                        day_next = nd_reg;
                    end
                end
            end
        end

        // A stale day past the month length rolls like the last day
        if (cmd.advance) begin
            if (!roll_day) begin
                day_next = day_reg + 5'd1;
            end else if (month_reg < MONTH_LAST) begin
                month_next = month_reg + 4'd1;
                day_next   = 5'd1;
            end else begin
                year_next  = year_reg + 12'd1;
                month_next = 4'd1;
                day_next   = 5'd1;
            end
        end

        if (cmd.count_dec) begin
            cnt_next = cnt_reg - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        end

        if (cmd.flag_ovf) begin
            status_next = STAT_OVERFLOW;
        end

        if (cmd.out_write) begin
            out_month_next  = month_reg;
            out_day_next    = day_reg;
            out_year_next   = year_reg;
            out_status_next = status_reg;
        end

        if (cmd.out_write) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            year_reg      <= YEAR_LOW;
            out_valid_reg <= 1'b0;
        end else begin
            month_reg     <= month_next;
            day_reg       <= day_next;
            year_reg      <= year_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_reg        <= cnt_next;
        cmd_reg        <= cmd_next;
        nm_reg         <= nm_next;
        nd_reg         <= nd_next;
        ny_reg         <= ny_next;
        status_reg     <= status_next;
        out_month_reg  <= out_month_next;
        out_day_reg    <= out_day_next;
        out_year_reg   <= out_year_next;
        out_status_reg <= out_status_next;
    end

    always_comb begin
        sts.cmd      = cmd_reg;
        sts.cnt_zero = (cnt_reg == '0);
        sts.at_end   = roll_day && (month_reg >= MONTH_LAST) && (year_reg >= YEAR_LAST);
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_month  = out_month_reg;
    assign out_day    = out_day_reg;
    assign out_year   = out_year_reg;
    assign out_status = out_status_reg;

    `CDC_ASSERT_NOW(a_month_range, 1'b1, (month_reg >= 4'd1) && (month_reg <= MONTH_LAST), "stored month out of range")
    `CDC_ASSERT_NOW(a_dec_nonzero, cmd.count_dec, cnt_reg != '0, "day counter decremented at zero")

endmodule

>>> hw/rtl/cdc_ctrl.sv
// Controller: sequences set, one-day step, counted advance and no-op.
`include "calendar_date_counter_assert.svh"

module cdc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cdc_pkg::ctrl_sts_t sts,
    output cdc_pkg::ctrl_cmd_t cmd
);
    import cdc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.cmd)
                    CMD_SET: begin
                        cmd.set_date = 1'b1;
                        state_next   = S_DONE;
                    end
                    CMD_STEP: begin
                        if (sts.at_end) begin
                            cmd.flag_ovf = 1'b1;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    CMD_COUNT: begin
                        if (sts.cnt_zero) begin
                            state_next = S_DONE;
                        end else if (sts.at_end) begin
                            cmd.flag_ovf = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            cmd.advance   = 1'b1;
                            cmd.count_dec = 1'b1;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CDC_ASSERT_NOW(a_out_free, cmd.out_write, sts.out_free, "result written over a pending one")
    `CDC_ASSERT_NEXT(a_load_exec, cmd.load, state_reg == S_EXEC, "accepted command not executed")

endmodule

>>> hw/rtl/calendar_date_counter.sv
// Top level of the calendar date counter: stream ports, controller and datapath.
//
// Keeps a Gregorian date (month, day, year; reset value 1 Jan 1900) and answers
// every input transfer with exactly one result transfer carrying the stored date
// after the command and a status code. Command 0 loads a date, checking the month
// (1-12), then the year (1900-2100), then the day against that month's length;
// fields that passed before a failure stay written. Command 1 advances one day.
// Command 2 advances day_count days (low COUNT_WIDTH bits), one day per clock in
// the datapath's increment logic. Command 3 does nothing. Past 31 Dec 4095 the
// date holds and status reads overflow; a counted advance drops the remaining days.
// Flow: one command is in flight at a time. Each command is accepted, executed
// (command 2 loops there over its days) and then handed off as a result; the
// hand-off waits while an older result is still unread. The result sits in an
// output register, so the next command is taken while a result still waits.
module calendar_date_counter #(
    parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // new_month[3:0], new_day[8:4], new_year[20:9],
                                       // day_count[36:21], zero[39:37]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // cur_month[3:0], cur_day[8:4], cur_year[20:9],
                                       // status[23:21]
);
    import cdc_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [11:0] out_year;
    logic [2:0]  out_status;

    // Sequencer: accept, execute (day by day for a counted advance), hand off result
    cdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (ctrl_sts),
        .cmd      (ctrl_cmd)
    );

    // Date registers, checks, day counter and result register
    cdc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (ctrl_cmd),
        .sts        (ctrl_sts),
        .in_cmd     (s_axis_tuser),
        .in_month   (s_axis_tdata[3:0]),
        .in_day     (s_axis_tdata[8:4]),
        .in_year    (s_axis_tdata[20:9]),
        .in_count   (s_axis_tdata[36:21]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_month  (out_month),
        .out_day    (out_day),
        .out_year   (out_year),
        .out_status (out_status)
    );

    // Pack result fields, lowest field in the lowest bits
    assign m_axis_tdata = {out_status, out_year, out_day, out_month};

endmodule

>>> test/testbench.sv
// Self-checking testbench for the calendar date counter: predicted dates vs. stream results.
module testbench;
    import cdc_pkg::*;

    // Command 3 has no name in the package; the block treats it as a no-op.
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Receiver stall modes
    localparam int SINK_OPEN    = 0;
    localparam int SINK_RANDOM  = 1;
    localparam int SINK_PATTERN = 2;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
        logic [15:0] count;
    } date_cmd_t;

    // Same bit order as the result tdata: month in the low bits, status on top.
    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] year;
        logic [4:0]  day;
        logic [3:0]  month;
    } date_result_t;

    // Keeps its own copy of the stored date and the queue of dates still owed by the block.
    class date_scoreboard;
        logic [3:0]   month;
        logic [4:0]   day;
        logic [11:0]  year;
        date_result_t owed_q[$];
        int           errors;

        function new();
            month  = 4'd1;
            day    = 5'd1;
            year   = YEAR_LOW;
            errors = 0;
        endfunction

        function bit leap_year(logic [11:0] y);
            int yi;
            yi = int'(y);
            return (yi % 400 == 0) || ((yi % 100 != 0) && (yi % 4 == 0));
        endfunction

        function int days_in(logic [3:0] m, logic [11:0] y);
            case (m)
                4'd0:                    return 0;
                4'd2:                    return leap_year(y) ? 29 : 28;
                4'd4, 4'd6, 4'd9, 4'd11: return 30;
                default:                 return 31;
            endcase
        endfunction

        function bit at_calendar_end();
            return (month == MONTH_LAST) && (day >= 5'd31) && (year == YEAR_LAST);
        endfunction

        // A day at or past the month's end (stale after a failed load) rolls to the 1st.
        function bit advance_day();
            if (int'(day) < days_in(month, year)) begin
                day = day + 5'd1;
            end else if (month < MONTH_LAST) begin
                month = month + 4'd1;
                day   = 5'd1;
            end else if (year >= YEAR_LAST) begin
                return 1'b0;
            end else begin
                year  = year + 12'd1;
                month = 4'd1;
                day   = 5'd1;
            end
            return 1'b1;
        endfunction

        // Fields that pass their check stay written even if a later one fails.
        function logic [2:0] load_date(logic [3:0] m, logic [4:0] d, logic [11:0] y);
            if (m < 4'd1 || m > MONTH_LAST) return STAT_BAD_MONTH;
            month = m;
            if (y < YEAR_LOW || y > YEAR_HIGH) return STAT_BAD_YEAR;
            year = y;
            if (d < 5'd1 || int'(d) > days_in(month, year)) return STAT_BAD_DAY;
            day = d;
            return STAT_OK;
        endfunction

        function void note_command(date_cmd_t c);
            date_result_t r;
            logic [2:0]   st;
            int           n;
            st = STAT_OK;
            case (c.cmd)
                CMD_SET:   st = load_date(c.month, c.day, c.year);
                CMD_STEP:  if (!advance_day()) st = STAT_OVERFLOW;
                CMD_COUNT: begin
                    for (n = 0; n < int'(c.count); n++) begin
                        if (!advance_day()) begin
                            st = STAT_OVERFLOW;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.month  = month;
            r.day    = day;
            r.year   = year;
            r.status = st;
            owed_q.push_back(r);
        endfunction

        function void field_diff(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] raw);
            date_result_t got, want;
            got = raw;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, raw);
                return;
            end
            want = owed_q.pop_front();
            field_diff("cur_month", want.month, got.month);
            field_diff("cur_day", want.day, got.day);
            field_diff("cur_year", want.year, got.year);
            field_diff("status", want.status, got.status);
        endfunction

        function void close_out();
            if (owed_q.size() != 0) begin
                errors++;
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, owed_q.size());
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    date_scoreboard board = new();
    date_cmd_t      cmd_q[$];
    int             n_queued = 0;
    int             n_accepted = 0;
    bit             long_hold_req = 1'b0;

    calendar_date_counter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Command source: bursts of random length, random gaps between them.
    initial begin : cmd_source
        date_cmd_t c;
        int        burst_left;
        int        gap_left;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = 1;
        gap_left      = 0;
        while (!aresetn) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (gap_left > 0 || cmd_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                c = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.cmd;
                s_axis_tdata  <= {3'b000, c.count, c.year, c.day, c.month};
                do @(posedge aclk); while (!s_axis_tready);
                board.note_command(c);
                n_accepted++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Result sink: random stall modes (open, random, pattern); one long hold-off on request.
    initial begin : result_sink
        int         mode;
        int         mode_left;
        int         held;
        logic [7:0] pat;
        m_axis_tready = 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        pat       = 8'hA5;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 1; held < LONG_HOLD; held++) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(SINK_OPEN, SINK_PATTERN);
                    mode_left = $urandom_range(20, 120);
                    pat       = 8'($urandom) | 8'h01;
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_axis_tready <= 1'b1;
                    SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        m_axis_tready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    task automatic put_cmd(logic [1:0] cmd, logic [3:0] m, logic [4:0] d, logic [11:0] y,
                           logic [15:0] n);
        date_cmd_t c;
        c.cmd   = cmd;
        c.month = m;
        c.day   = d;
        c.year  = y;
        c.count = n;
        cmd_q.push_back(c);
        n_queued++;
    endtask

    // Unused fields carry random junk; the block must ignore them.
    task automatic put_set(logic [3:0] m, logic [4:0] d, logic [11:0] y);
        put_cmd(CMD_SET, m, d, y, 16'($urandom));
    endtask

    task automatic put_step();
        put_cmd(CMD_STEP, 4'($urandom), 5'($urandom), 12'($urandom), 16'($urandom));
    endtask

    task automatic put_count(logic [15:0] n);
        put_cmd(CMD_COUNT, 4'($urandom), 5'($urandom), 12'($urandom), n);
    endtask

    task automatic put_nop();
        put_cmd(CMD_NOP, 4'($urandom), 5'($urandom), 12'($urandom), 16'($urandom));
    endtask

    // Sender holds back until every transfer is taken and every result has come.
    task automatic settle();
        while (n_accepted != n_queued || board.owed_q.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          i;
        int          pick;
        int          len;
        int          big_left;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [11:0] y;
        logic [15:0] n;

        while (!aresetn) @(posedge aclk);

        // Directed: leap rule, failed-load leftovers, stale day, rollovers.
        put_step();                        // from the reset date
        put_set(4'd0, 5'd1, 12'd2000);     // month zero
        put_set(4'd15, 5'd31, 12'd4095);   // all fields at their top
        put_set(4'd2, 5'd29, 12'd1900);    // century, not leap
        put_set(4'd2, 5'd29, 12'd2000);    // div 400, leap
        put_set(4'd2, 5'd29, 12'd2100);    // century, not leap
        put_set(4'd2, 5'd29, 12'd2024);
        put_step();                        // leap Feb 29 -> Mar 1
        put_set(4'd12, 5'd31, 12'd2100);
        put_step();                        // year rollover
        put_set(4'd13, 5'd1, 12'd2000);    // month just past 12
        put_set(4'd5, 5'd10, 12'd1899);    // year just below range, month kept
        put_set(4'd6, 5'd0, 12'd2000);     // day zero
        put_set(4'd1, 5'd31, 12'd2000);
        put_set(4'd2, 5'd30, 12'd2001);    // bad day leaves day 31 in February
        put_step();                        // stale day rolls to Mar 1
        put_cmd(CMD_COUNT, 4'hF, 5'h1F, 12'hFFF, 16'h0000);  // zero count
        put_nop();
        put_count(16'd366);
        put_set(4'd12, 5'd31, 12'd2100);
        settle();

        // Run up to the last date that can be kept; the final count overflows.
        while (!board.at_calendar_end()) begin
            put_count(16'hFFFF);
            settle();
        end
        put_step();                        // overflow, date held
        put_count(16'd3);                  // overflow, rest dropped
        put_count(16'd0);
        put_nop();
        put_set(4'd1, 5'd1, 12'd1900);
        settle();

        // Random: mostly valid loads and short advances, some noise.
        big_left = 3;
        for (i = 0; i < 65; i++) begin
            if (i == 10) long_hold_req = 1'b1;  // sink stalls while commands keep coming
            if (i == 45) settle();
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                m   = 4'($urandom_range(1, 12));
                y   = 12'($urandom_range(YEAR_LOW, YEAR_HIGH));
                len = board.days_in(m, y);
                if (pick < 5)       d = 5'(len + 1);
                else if (pick < 18) d = 5'(len);
                else                d = 5'($urandom_range(1, len));
                put_set(m, d, y);
            end else if (pick < 40) begin
                put_set(4'($urandom), 5'($urandom), 12'($urandom));
            end else if (pick < 65) begin
                put_step();
            end else if (pick < 92) begin
                n = 16'($urandom_range(0, 40));
                if (big_left > 0 && $urandom_range(0, 20) == 0) begin
                    n = 16'($urandom);
                    big_left--;
                end
                put_count(n);
            end else begin
                put_nop();
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        board.close_out();
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
